// ===== hdl/mdfe_pkg.sv =====
// shared types and constants for the marker delimited field extractor
package mdfe_pkg;

  // input item kinds carried on s_tuser
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // result status codes carried in m_tuser[1:0]
  localparam logic [1:0] STATUS_FOUND      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
  localparam logic [1:0] STATUS_READ_ERROR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MARKER_BYTES  = 2'd0;
  localparam logic [1:0] REG_MARKER_LENGTH = 2'd1;
  localparam logic [1:0] REG_BUFFER_SIZE   = 2'd2;

  localparam logic [7:0]  SPACE_BYTE = 8'h20;
  localparam logic [15:0] COUNT_MAX  = 16'hffff;

  // what the output register loads
  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_TERM,
    OUT_EMPTY,
    OUT_TEXT
  } out_op_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    accept;
    out_op_t out_op;
    logic    len_dec;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_emit;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic term;
    logic end_match;
    logic len_zero;
    logic rd_space;
    logic idx_last;
  } dp_sts_t;

endpackage

// ===== hdl/mdfe_ram.sv =====
// generic single write port ram with registered read
module mdfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/mdfe_ctrl.sv =====
// controller: input acceptance, trailing space scan and text emission sequence
module mdfe_ctrl
  import mdfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_EMPTY
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE) && sts.out_free;

  // next state and datapath commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.out_op  = OUT_NONE;
    case (state)
      S_IDLE: begin
        cmd.accept = s_tvalid && s_tready;
        if (cmd.accept) begin
          if (sts.term) begin
            cmd.out_op = OUT_TERM;
          end else if (sts.end_match) begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        // read of the byte at len-1 is in flight
        if (sts.len_zero) begin
          state_next = S_EMPTY;
        end else begin
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.rd_space) begin
          cmd.len_dec = 1'b1;
          state_next  = S_SCAN_RD;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
        state_next  = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.rd_emit = 1'b1;
        if (sts.out_free) begin
          cmd.out_op  = OUT_TEXT;
          cmd.idx_inc = 1'b1;
          state_next  = sts.idx_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_op = OUT_EMPTY;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/mdfe_datapath.sv =====
// datapath: config registers, marker window, capture store and output register
module mdfe_datapath
  import mdfe_pkg::*;
#(
  parameter int MAX_MARKER = 8,
  parameter int MAX_TEXT   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  ctrl_cmd_t   cmd,
  output dp_sts_t     sts
);

  localparam int WW = 8 * MAX_MARKER;
  localparam int FW = $clog2(MAX_MARKER + 1);
  localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int LW = $clog2(MAX_TEXT + 1);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_CAPTURE
  } phase_t;

  // configuration registers
  logic [63:0] marker_bytes;
  logic [3:0]  marker_length;
  logic [5:0]  buffer_size;

  // stream state
  phase_t        phase;
  logic [WW-1:0] recent_bytes;
  logic [FW-1:0] window_fill;
  logic [15:0]   capture_count;

  // emission state
  logic [LW-1:0] len;
  logic [LW-1:0] idx;

  logic [3:0]    mlen;
  logic [5:0]    cap_raw;
  logic [6:0]    cap;
  logic          is_data;
  logic          is_capture;
  logic [WW-1:0] win_base;
  logic [FW-1:0] fill_base;
  logic [15:0]   count_base;
  logic [WW-1:0] win_next;
  logic [FW-1:0] fill_next;
  logic [15:0]   count_next;
  logic          fwd_match;
  logic          rev_match;
  logic [15:0]   len_full;
  logic [15:0]   len_cut;
  logic [LW-1:0] len_m1;
  logic          ram_wr_en;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;
  logic          out_free;

  // effective marker length and text capacity
  always_comb begin
    mlen = marker_length;
    if (mlen == 4'd0) begin
      mlen = 4'd1;
    end
    if (mlen > 4'(MAX_MARKER)) begin
      mlen = 4'(MAX_MARKER);
    end
    cap_raw = (buffer_size == 6'd0) ? 6'd0 : buffer_size - 6'd1;
    cap     = ({1'b0, cap_raw} > 7'(MAX_TEXT)) ? 7'(MAX_TEXT) : {1'b0, cap_raw};
  end

  // window shift and marker compares on the incoming byte
  always_comb begin
    logic [WW+7:0] shifted;
    logic [3:0]    rsel;
    is_data    = (s_tuser == KIND_DATA);
    is_capture = is_data && ((phase == PH_CAPTURE) ||
                             ((phase == PH_SKIP) && (s_tdata != SPACE_BYTE)));
    if (phase == PH_CAPTURE || phase == PH_SEARCH) begin
      win_base   = recent_bytes;
      fill_base  = window_fill;
      count_base = capture_count;
    end else begin
      win_base   = '0;
      fill_base  = '0;
      count_base = '0;
    end
    shifted    = {win_base, s_tdata};
    win_next   = shifted[WW-1:0];
    fill_next  = (fill_base < FW'(MAX_MARKER)) ? fill_base + 1'b1 : fill_base;
    count_next = (count_base < COUNT_MAX) ? count_base + 16'd1 : count_base;
    fwd_match  = (4'(fill_next) >= mlen);
    rev_match  = (4'(fill_next) >= mlen);
    for (int k = 0; k < MAX_MARKER; k++) begin
      rsel = mlen - 4'd1 - 4'(k);
      if (4'(k) < mlen) begin
        if (win_next[8*k +: 8] != marker_bytes[8*k +: 8]) begin
          rev_match = 1'b0;
        end
        if (win_next[8*k +: 8] != marker_bytes[{rsel[2:0], 3'b000} +: 8]) begin
          fwd_match = 1'b0;
        end
      end
    end
  end

  // text length at the end marker, cut to the capacity
  always_comb begin
    len_full = (count_next >= {12'd0, mlen}) ? count_next - {12'd0, mlen} : 16'd0;
    len_cut  = (len_full > {9'd0, cap}) ? {9'd0, cap} : len_full;
    len_m1   = len - 1'b1;
  end

  // capture store
  assign ram_wr_en   = cmd.accept && is_capture && (count_base < {9'd0, cap});
  assign ram_rd_addr = cmd.rd_emit ? idx[AW-1:0] : len_m1[AW-1:0];

  mdfe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_TEXT)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_base[AW-1:0]),
    .wr_data (s_tdata),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // status to the controller
  assign out_free      = !m_tvalid || m_tready;
  assign sts.out_free  = out_free;
  assign sts.term      = (s_tuser == KIND_END) || (s_tuser == KIND_ERROR);
  assign sts.end_match = is_capture && rev_match;
  assign sts.len_zero  = (len == '0);
  assign sts.rd_space  = (ram_rd_data == SPACE_BYTE);
  assign sts.idx_last  = (idx == len_m1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_bytes  <= '0;
      marker_length <= 4'd1;
      buffer_size   <= 6'd33;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MARKER_BYTES:  marker_bytes  <= cfg_data;
        REG_MARKER_LENGTH: marker_length <= cfg_data[3:0];
        REG_BUFFER_SIZE:   buffer_size   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // stream state: search, skip and capture phases
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEARCH;
      window_fill   <= '0;
      capture_count <= '0;
    end else if (cmd.accept) begin
      if (sts.term) begin
        phase         <= PH_SEARCH;
        window_fill   <= '0;
        capture_count <= '0;
      end else if (is_capture) begin
        if (rev_match) begin
          phase         <= PH_SEARCH;
          window_fill   <= '0;
          capture_count <= '0;
        end else begin
          phase         <= PH_CAPTURE;
          window_fill   <= fill_next;
          capture_count <= count_next;
        end
      end else if (is_data && phase != PH_SKIP) begin
        if (fwd_match) begin
          phase       <= PH_SKIP;
          window_fill <= '0;
        end else begin
          phase       <= PH_SEARCH;
          window_fill <= fill_next;
        end
        capture_count <= '0;
      end
    end
  end

  // window bytes need no reset, the fill count qualifies them
  always_ff @(posedge clk) begin
    if (cmd.accept && is_data) begin
      recent_bytes <= win_next;
    end
  end

  // length and index counters for the scan and emission
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.end_match) begin
      len <= len_cut[LW-1:0];
    end else if (cmd.len_dec) begin
      len <= len_m1;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_op != OUT_NONE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.out_op)
      OUT_TERM: begin
        m_tdata <= '0;
        m_tuser <= {1'b0, (s_tuser == KIND_END) ? STATUS_NOT_FOUND : STATUS_READ_ERROR};
        m_tlast <= 1'b1;
      end
      OUT_EMPTY: begin
        m_tdata <= '0;
        m_tuser <= {1'b0, STATUS_FOUND};
        m_tlast <= 1'b1;
      end
      OUT_TEXT: begin
        m_tdata <= ram_rd_data;
        m_tuser <= {1'b1, STATUS_FOUND};
        m_tlast <= sts.idx_last;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/marker_delimited_field_extract_top.sv =====
// top level of the marker delimited field extractor
//
//  channel  direction  transfer when          payload
//  s_*      in         s_tvalid & s_tready    tdata: data_byte; tuser: kind
//  m_*      out        m_tvalid & m_tready    tdata: text_byte; tuser: status, has_byte; tlast
//  cfg_*    in         cfg_valid & cfg_ready  cfg_index, cfg_data (always ready)
//
// searching, skipping and capturing take one input byte per cycle
// on the end marker the input stalls: trailing spaces are scanned with a store
// read and a check per stripped byte, then each text byte is read from the store and sent
// the input also stalls while the output register holds an untaken result
// reset is synchronous; the capture store needs no clearing pass
module marker_delimited_field_extract_top
  import mdfe_pkg::*;
#(
  parameter int MAX_MARKER = 8,
  parameter int MAX_TEXT   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] text_byte
  output logic [2:0]  m_tuser,   // [1:0] status, [2] has_byte
  output logic        m_tlast
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  // sequencer
  mdfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  mdfe_datapath #(
    .MAX_MARKER (MAX_MARKER),
    .MAX_TEXT   (MAX_TEXT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== hdl/mdfe_checker.sv =====
// port level checks for the marker delimited field extractor
module mdfe_checker
  import mdfe_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
      $stable(m_tlast))
    else $error("stalled result changed");

  // not found and read error results carry no byte and end the run
  a_term_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] != STATUS_FOUND) |-> m_tlast && !m_tuser[2])
    else $error("terminal result malformed");

  // a result without a byte has zero data and is the last one
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> m_tdata == 8'd0 && m_tlast)
    else $error("byteless result malformed");

  // end of stream gives a not found result in the next cycle
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_END) |=>
      m_tvalid && (m_tuser[1:0] == STATUS_NOT_FOUND) && m_tlast)
    else $error("end of stream result missing");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind marker_delimited_field_extract_top mdfe_checker u_mdfe_checker (.*);
